// ===== sv/spds_pkg.sv =====
// ----------------------------------------------------------------------------
// spds_pkg
// Shared types and constants for the square path drive sequencer.
// ----------------------------------------------------------------------------
package spds_pkg;

    typedef enum logic [1:0] {
        PH_WAITING  = 2'd0,
        PH_DRIVING  = 2'd1,
        PH_TURNING  = 2'd2,
        PH_COMPLETE = 2'd3
    } phase_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LENGTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOLERANCE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SPEED       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_SPEED      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LOOPS          = 3'd5;

    localparam logic [17:0] QUARTER_TURN = 18'd16384;
    localparam logic [16:0] TURN_SUM_MAX = 17'h1FFFF;
    localparam logic [9:0]  SIDE_MAX     = 10'd1023;

    typedef struct packed {
        logic        [15:0] segment_length;
        logic        [15:0] position_tolerance;
        logic        [14:0] angle_tolerance;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic        [7:0]  num_loops;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic signed [23:0] start_x;
        logic signed [23:0] start_y;
        logic        [15:0] last_heading;
        logic        [16:0] turn_sum;
        logic        [9:0]  side_count;
    } state_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic        [15:0] heading;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] linear_cmd;
        logic signed [15:0] angular_cmd;
        logic               finished;
        logic        [9:0]  sides_done;
    } cmd_t;

    localparam cfg_t CFG_RST = '{
        segment_length:     16'd1000,
        position_tolerance: 16'd20,
        angle_tolerance:    15'd182,
        linear_speed:       16'sd200,
        angular_speed:      16'sd5215,
        num_loops:          8'd1
    };

    localparam state_t STATE_RST = '{
        phase:        PH_WAITING,
        start_x:      24'sd0,
        start_y:      24'sd0,
        last_heading: 16'd0,
        turn_sum:     17'd0,
        side_count:   10'd0
    };

endpackage

// ===== sv/spds_step.sv =====
// ----------------------------------------------------------------------------
// spds_step
// Next-state and command logic for one pose item: distance test, wrapped
// heading step accumulation, side and loop bookkeeping.
// ----------------------------------------------------------------------------
module spds_step
    import spds_pkg::*;
(
    input  state_t st,
    input  cfg_t   cfg,
    input  pose_t  pose,
    output state_t st_next,
    output cmd_t   cmd
);

    logic signed [23:0] sx_eff;
    logic signed [23:0] sy_eff;
    logic        [15:0] last_eff;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic        [23:0] adx;
    logic        [23:0] ady;
    logic        [47:0] sq_x;
    logic        [47:0] sq_y;
    logic        [48:0] d2;
    logic               need_pos;
    logic        [15:0] need;
    logic        [31:0] need_sq;
    logic               drive_more;
    logic        [15:0] hd_step;
    logic        [15:0] mag;
    logic               turning;
    logic        [17:0] tsum_wide;
    logic        [16:0] tsum_sat;
    logic               turn_more;
    logic        [9:0]  sc_inc;
    logic               all_done;

    always_comb begin
        sx_eff   = (st.phase == PH_WAITING) ? pose.pos_x : st.start_x;
        sy_eff   = (st.phase == PH_WAITING) ? pose.pos_y : st.start_y;
        last_eff = (st.phase == PH_WAITING) ? pose.heading : st.last_heading;

        dx  = {pose.pos_x[23], pose.pos_x} - {sx_eff[23], sx_eff};
        dy  = {pose.pos_y[23], pose.pos_y} - {sy_eff[23], sy_eff};
        adx = dx[24] ? 24'(-dx) : dx[23:0];
        ady = dy[24] ? 24'(-dy) : dy[23:0];
        sq_x = adx * adx;
        sq_y = ady * ady;
        d2   = {1'b0, sq_x} + {1'b0, sq_y};

        need_pos   = cfg.segment_length > cfg.position_tolerance;
        need       = cfg.segment_length - cfg.position_tolerance;
        need_sq    = need * need;
        drive_more = need_pos && (d2 < {17'd0, need_sq});

        // wrapped step magnitude; a half-turn step counts as 32768
        turning = (st.phase == PH_TURNING);
        hd_step = pose.heading - last_eff;
        mag     = hd_step[15] ? 16'(17'h10000 - {1'b0, hd_step}) : hd_step;

        tsum_wide = turning ? ({1'b0, st.turn_sum} + {2'b00, mag}) : 18'd0;
        tsum_sat  = tsum_wide[17] ? TURN_SUM_MAX : tsum_wide[16:0];
        turn_more = ({1'b0, tsum_sat} + {3'b000, cfg.angle_tolerance}) < QUARTER_TURN;

        sc_inc   = (st.side_count == SIDE_MAX) ? st.side_count : st.side_count + 10'd1;
        all_done = sc_inc >= {cfg.num_loops, 2'b00};

        st_next         = st;
        cmd.linear_cmd  = 16'sd0;
        cmd.angular_cmd = 16'sd0;
        cmd.finished    = 1'b0;
        cmd.sides_done  = st.side_count;

        case (st.phase)
            PH_COMPLETE: begin
                cmd.finished = 1'b1;
            end
            default: begin
                st_next.start_x      = sx_eff;
                st_next.start_y      = sy_eff;
                st_next.last_heading = pose.heading;
                if (!turning && drive_more) begin
                    st_next.phase  = PH_DRIVING;
                    cmd.linear_cmd = cfg.linear_speed;
                end else begin
                    st_next.turn_sum = tsum_sat;
                    if (turn_more) begin
                        st_next.phase   = PH_TURNING;
                        cmd.angular_cmd = cfg.angular_speed;
                    end else begin
                        st_next.side_count = sc_inc;
                        cmd.sides_done     = sc_inc;
                        if (all_done) begin
                            st_next.phase = PH_COMPLETE;
                            cmd.finished  = 1'b1;
                        end else begin
                            st_next.start_x = pose.pos_x;
                            st_next.start_y = pose.pos_y;
                            st_next.phase   = PH_DRIVING;
                            cmd.linear_cmd  = cfg.linear_speed;
                        end
                    end
                end
            end
        endcase
    end

endmodule

// ===== sv/square_path_drive_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// square_path_drive_sequencer_core
// Pipeline: an accepted item is held in the input reg, then its result is
// registered in the result reg once the output can advance. Throughput:
// one item per cycle unless a held result stalls it; the step logic (two
// 24x24 squares, one 16x16 square, a 49-bit compare) ends an item in one pass.
// Reset: valids clear, cfg and state to defaults, phase waiting, counters zero.
// ----------------------------------------------------------------------------
module square_path_drive_sequencer_core
    import spds_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [23:0]    s_pos_x,
    input  logic signed [23:0]    s_pos_y,
    input  logic        [15:0]    s_heading,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_linear_cmd,
    output logic signed [15:0]    m_angular_cmd,
    output logic                  m_finished,
    output logic        [9:0]     m_sides_done
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    pose_t  pose_reg;
    cmd_t   cmd_reg;
    cmd_t   cmd_next;
    logic   in_valid_reg;
    logic   out_valid_reg;
    logic   advance;
    logic   fire;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    spds_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .pose    (pose_reg),
        .st_next (state_next),
        .cmd     (cmd_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RST;
            cfg_reg       <= CFG_RST;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                state_reg <= state_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SEGMENT_LENGTH:     cfg_reg.segment_length     <= cfg_wdata;
                    CFG_POSITION_TOLERANCE: cfg_reg.position_tolerance <= cfg_wdata;
                    CFG_ANGLE_TOLERANCE:    cfg_reg.angle_tolerance    <= cfg_wdata[14:0];
                    CFG_LINEAR_SPEED:       cfg_reg.linear_speed       <= cfg_wdata;
                    CFG_ANGULAR_SPEED:      cfg_reg.angular_speed      <= cfg_wdata;
                    CFG_NUM_LOOPS:          cfg_reg.num_loops          <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pose_reg.pos_x   <= s_pos_x;
            pose_reg.pos_y   <= s_pos_y;
            pose_reg.heading <= s_heading;
        end
        if (fire) begin
            cmd_reg <= cmd_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_linear_cmd  = cmd_reg.linear_cmd;
    assign m_angular_cmd = cmd_reg.angular_cmd;
    assign m_finished    = cmd_reg.finished;
    assign m_sides_done  = cmd_reg.sides_done;

    // complete holds until reset
    a_complete_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_COMPLETE |=> state_reg.phase == PH_COMPLETE)
        else $error("complete phase left without reset");

    a_finished_idle_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && cmd_reg.finished |->
            cmd_reg.linear_cmd == 16'sd0 && cmd_reg.angular_cmd == 16'sd0)
        else $error("nonzero command after finish");

    a_sides_not_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.side_count != 10'd0 |-> state_reg.phase != PH_WAITING)
        else $error("sides counted while waiting");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled without a blocked result");

endmodule
